FILE: rtl/dhc_pkg.sv
// Package for the depth histogram colorizer: word types, bin table geometry,
// controller states. Depends on nothing.
`default_nettype none
package dhc_pkg;

	// Depth samples are shifted down into one of 8192 bins
	localparam int DEPTH_SHIFT = 3;
	localparam int BIN_W       = 13;
	localparam int BIN_COUNT   = 8192;
	localparam int LEVEL_W     = 8;

	typedef struct packed {
		logic        kind;
		logic [15:0] depth;
		logic        last;
	} in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last_out;
	} out_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD_RMW,
		ST_SCAN,
		ST_RD_BIN,
		ST_RD_CUM,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/dhc_frame_store.sv
// Frame store: one bin index per loaded pixel, single write and single read port.
// Depends on dhc_pkg.
`default_nettype none
module dhc_frame_store
	import dhc_pkg::*;
#(
	parameter int AW = 16
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [BIN_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [BIN_W-1:0] rdata
);

	logic [BIN_W-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dhc_bin_table.sv
// Histogram / cumulative table memory, one write and one read port.
// Depends on dhc_pkg.
`default_nettype none
module dhc_bin_table
	import dhc_pkg::*;
#(
	parameter int CW = 17
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [BIN_W-1:0] waddr,
	input  wire logic [CW-1:0]    wdata,
	input  wire logic             re,
	input  wire logic [BIN_W-1:0] raddr,
	output logic      [CW-1:0]    rdata
);

	logic [CW-1:0] mem [BIN_COUNT];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dhc_divider.sv
// Restoring divider: 8 quotient bits of (rem * 256) / dvs, one bit per cycle,
// saturating at 255 when rem equals dvs. Depends on dhc_pkg.
`default_nettype none
module dhc_divider
	import dhc_pkg::*;
#(
	parameter int W = 17
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [W-1:0]       rem,
	input  wire logic [W-1:0]       dvs,
	output logic                    done,
	output logic      [LEVEL_W-1:0] quot
);

	logic [W:0]         r_q;
	logic [W-1:0]       d_q;
	logic [LEVEL_W-1:0] q_q;
	logic [2:0]         cnt_q;
	logic               busy_q;
	logic               sat_q;
	logic               done_q;
	logic [W:0]         r2;
	logic               ge;

	// one trial subtraction per cycle
	always_comb begin
		r2 = {r_q[W-1:0], 1'b0};
		ge = (r2 >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= {1'b0, rem};
			d_q   <= dvs;
			sat_q <= (rem == dvs);
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= ge ? (r2 - {1'b0, d_q}) : r2;
			q_q <= {q_q[LEVEL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sat_q ? '1 : q_q;

endmodule
`default_nettype wire

FILE: rtl/depth_histogram_colorizer_unit.sv
// Top level of the depth histogram colorizer: controller, counters, output register.
// Depends on dhc_pkg, dhc_frame_store, dhc_bin_table, dhc_divider.
//
//  channel | handshake            | word
//  in      | in_valid / in_ready  | in_word  (kind, depth, last)
//  out     | out_valid / out_ready| out_word (level, last_out)
//
// Load word: when the pixel falls in a nonzero bin it also takes a histogram
// read-modify-write on the bin table port. The last pixel adds a cumulative
// sweep over all bins. Read word: frame store read, bin table read, divider,
// output; the divider is skipped when the level is zero. After reset and after
// each frame is drained the bin table is cleared bin by bin, with in_ready low.
// A stalled output holds only the word in the output register; a new word is
// taken while it waits.
`default_nettype none
module depth_histogram_colorizer_unit
	import dhc_pkg::*;
#(
	parameter int MAX_PIXELS = 65536
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_word,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_word
);

	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	state_t state_q, state_d;

	logic [CW-1:0]    loaded_q, nz_q, rp_q, acc_q;
	logic             frame_ready_q;
	logic [BIN_W-1:0] clr_q, bin_s1, wa_s1;
	logic [BIN_W:0]   scan_q;
	logic             v_s1, last_s1, final_s1, bin0_s1;
	logic             out_valid_q;
	out_t             out_q;
	logic [LEVEL_W-1:0] lvl_q;

	logic             fs_we, fs_re, bt_we, bt_re;
	logic [AW-1:0]    fs_waddr, fs_raddr;
	logic [BIN_W-1:0] fs_rdata, bt_waddr, bt_raddr, in_bin;
	logic [CW-1:0]    bt_wdata, bt_rdata;
	logic             acc, ld, st, hit, rd, rdok, scan_done, zero_lvl, out_free;
	logic             div_start, div_done;
	logic [LEVEL_W-1:0] div_quot;

	// decode of the accepted word
	always_comb begin
		in_bin    = in_word.depth[15:DEPTH_SHIFT];
		acc       = in_valid && in_ready;
		ld        = acc && (in_word.kind == KIND_LOAD) && !frame_ready_q;
		st        = ld && (loaded_q < CW'(MAX_PIXELS));
		hit       = st && (in_bin != '0);
		rd        = acc && (in_word.kind == KIND_READ) && frame_ready_q;
		rdok      = rd && (rp_q < loaded_q);
		scan_done = v_s1 && (wa_s1 == '1);
		zero_lvl  = bin0_s1 || (nz_q == '0) || (bt_rdata >= nz_q);
		out_free  = !out_valid_q || out_ready;
		div_start = (state_q == ST_RD_CUM) && !zero_lvl;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (hit) state_d = ST_LD_RMW;
				else if (ld && in_word.last) state_d = ST_SCAN;
				else if (rdok) state_d = ST_RD_BIN;
				else if (rd) state_d = ST_CLEAR;
			end
			ST_LD_RMW: state_d = last_s1 ? ST_SCAN : ST_IDLE;
			ST_SCAN:   if (scan_done) state_d = ST_IDLE;
			ST_RD_BIN: state_d = ST_RD_CUM;
			ST_RD_CUM: state_d = zero_lvl ? ST_OUT : ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = final_s1 ? ST_CLEAR : ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// memory port control
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		fs_we    = st;
		fs_waddr = loaded_q[AW-1:0];
		fs_re    = rdok;
		fs_raddr = rp_q[AW-1:0];
		bt_we    = 1'b0;
		bt_waddr = clr_q;
		bt_wdata = '0;
		bt_re    = 1'b0;
		bt_raddr = in_bin;
		case (state_q)
			ST_CLEAR: bt_we = 1'b1;
			ST_IDLE:  bt_re = hit;
			ST_LD_RMW: begin
				bt_we    = 1'b1;
				bt_waddr = bin_s1;
				bt_wdata = bt_rdata + CW'(1);
			end
			ST_SCAN: begin
				bt_we    = v_s1;
				bt_waddr = wa_s1;
				bt_wdata = acc_q + bt_rdata;
				bt_re    = !scan_q[BIN_W];
				bt_raddr = scan_q[BIN_W-1:0];
			end
			ST_RD_BIN: begin
				bt_re    = 1'b1;
				bt_raddr = fs_rdata;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			loaded_q      <= '0;
			nz_q          <= '0;
			rp_q          <= '0;
			frame_ready_q <= 1'b0;
			scan_q        <= '0;
			v_s1          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// output word is loaded in ST_OUT, dropped once taken
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q         <= clr_q + BIN_W'(1);
					loaded_q      <= '0;
					nz_q          <= '0;
					rp_q          <= '0;
					frame_ready_q <= 1'b0;
				end
				ST_IDLE: begin
					if (st) loaded_q <= loaded_q + CW'(1);
					if (rdok) rp_q <= rp_q + CW'(1);
					scan_q <= '0;
					v_s1   <= 1'b0;
				end
				ST_LD_RMW: nz_q <= nz_q + CW'(1);
				ST_SCAN: begin
					if (!scan_q[BIN_W]) scan_q <= scan_q + (BIN_W+1)'(1);
					v_s1 <= !scan_q[BIN_W];
					if (scan_done) frame_ready_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			bin_s1   <= in_bin;
			last_s1  <= in_word.last;
			final_s1 <= (rp_q + CW'(1) == loaded_q);
			acc_q    <= '0;
		end
		if (state_q == ST_SCAN) begin
			wa_s1 <= scan_q[BIN_W-1:0];
			if (v_s1) acc_q <= acc_q + bt_rdata;
		end
		if (state_q == ST_RD_BIN) bin0_s1 <= (fs_rdata == '0);
		if (state_q == ST_RD_CUM && zero_lvl) lvl_q <= '0;
		else if (div_done) lvl_q <= div_quot;
		if (state_q == ST_OUT && out_free) begin
			out_q.level    <= lvl_q;
			out_q.last_out <= final_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	dhc_frame_store #(.AW(AW)) u_frame_store (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (in_bin),
		.re    (fs_re),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	dhc_bin_table #(.CW(CW)) u_bin_table (
		.clk   (clk),
		.we    (bt_we),
		.waddr (bt_waddr),
		.wdata (bt_wdata),
		.re    (bt_re),
		.raddr (bt_raddr),
		.rdata (bt_rdata)
	);

	dhc_divider #(.W(CW)) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rem    (nz_q - bt_rdata),
		.dvs    (nz_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// readout never runs past the loaded pixels
	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= loaded_q) else $error("read pointer beyond loaded count");

	// nonzero count is a subset of loaded pixels
	a_nz_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nz_q <= loaded_q) else $error("nonzero count exceeds loaded count");

	// no histogram update once the frame has closed
	a_no_rmw_ready: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ready_q |-> state_q != ST_LD_RMW) else $error("load after frame close");

	// divider only finishes while the controller waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("stray divider result");

endmodule
`default_nettype wire
